>>> sv/twa_pkg.sv
// twa_pkg: widths, fixed-point constants, latencies, shared types and the arctangent table
// for the twist warp source address core. Depends on nothing; every other file imports it.
package twa_pkg;

   // field and register widths
   localparam int DIM_W           = 13;
   localparam int COORD_W         = 12;
   localparam int TIME_W          = 63;
   localparam int CYC_W           = 32;
   localparam int IDX_W           = 26;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int MAX_DIM         = 4096;
   localparam int BYTES_PER_PIXEL = 4;

   // internal fixed-point widths
   localparam int ANG_W    = 19;
   localparam int FRAC_W   = 17;
   localparam int DELTA_W  = 13;
   localparam int CORDIC_W = 20;
   localparam int ROOT_W   = 32;
   localparam int SREM_W   = 36;
   localparam int PROD_W   = DELTA_W + CORDIC_W;
   localparam int SUM_W    = 36;

   // pipeline depths
   localparam int MOD_STEPS    = TIME_W;
   localparam int TP_STEPS     = 16;
   localparam int SQRT_STEPS   = 40;
   localparam int RATIO_STEPS  = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int ANG_LAT      = 1 + MOD_STEPS + 1 + TP_STEPS + 1;
   localparam int RAT_LAT      = 4 + SQRT_STEPS + 1 + RATIO_STEPS + 1;
   localparam int PAD_LAT      = ANG_LAT - RAT_LAT;
   localparam int ROT_LAT      = 2 + CORDIC_STEPS + 3;

   // Q16 constants
   localparam logic [17:0] PI_Q16 = 18'd205887;
   localparam int HALF_PI_Q16     = 102944;
   localparam int CORDIC_GAIN     = 39797;
   localparam int ONE_Q16         = 65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_CYCLE  = 2'd2
   } csr_index_type;

   // effective configuration seen by the datapath
   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [COORD_W-1:0] centre_x;
      logic [COORD_W-1:0] centre_y;
      logic [CYC_W-1:0]   cycle;
   } cfg_type;

   // geometry results handed from the ratio pipeline to the rotator
   typedef struct packed {
      logic [FRAC_W-1:0]         frac;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [IDX_W-1:0]          dest_index;
   } ratio_type;

   // arctangent of 2^-step in Q16 radians
   function automatic logic [15:0] atan_q16(input int step);
      logic [15:0] v;
      case (step)
         0:       v = 16'd51472;
         1:       v = 16'd30386;
         2:       v = 16'd16055;
         3:       v = 16'd8150;
         4:       v = 16'd4091;
         5:       v = 16'd2047;
         6:       v = 16'd1024;
         7:       v = 16'd512;
         8:       v = 16'd256;
         9:       v = 16'd128;
         10:      v = 16'd64;
         11:      v = 16'd32;
         12:      v = 16'd16;
         13:      v = 16'd8;
         14:      v = 16'd4;
         default: v = 16'd2;
      endcase
      return v;
   endfunction

   // zero dimension reads as one, oversize as the maximum
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      else r = v;
      return r;
   endfunction

endpackage

>>> sv/twa_angle.sv
// twa_angle: twist angle from the frame time: bit-serial modulo pipeline, phase divider
// pipeline and the pi scaling multiply. Depends on twa_pkg.
module twa_angle (
   input  logic                              clock,
   input  logic                              reset,
   input  twa_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   input  logic [twa_pkg::TIME_W-1:0]        in_time,
   output logic                              out_valid,
   output logic signed [twa_pkg::ANG_W-1:0]  out_angle
);
   import twa_pkg::*;

   logic [ANG_LAT-1:0]  valid_ff;
   logic [CYC_W-1:0]    mod_rem_ff  [0:MOD_STEPS];
   logic [TIME_W-1:0]   mod_time_ff [0:MOD_STEPS];
   logic [FRAC_W-1:0]   tp_q_ff     [0:TP_STEPS];
   logic [CYC_W-1:0]    tp_rem_ff   [0:TP_STEPS];
   logic signed [ANG_W-1:0] angle_ff;

   logic [CYC_W:0]      two_r;
   logic [CYC_W:0]      num;
   logic [CYC_W:0]      num_diff;
   logic [FRAC_W-1:0]   tp_q_in;
   logic [CYC_W-1:0]    tp_rem_in;
   logic                tp_neg;
   logic [FRAC_W:0]     two_tp;
   logic [FRAC_W-1:0]   tp_mag;
   logic [34:0]         ang_prod;
   logic signed [ANG_W-1:0] angle_in;

   // valid bits travel alongside the data
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[ANG_LAT-2:0], in_valid};
   end

   // input stage
   always_ff @(posedge clock) begin
      mod_rem_ff[0]  <= '0;
      mod_time_ff[0] <= in_time;
   end

   // time modulo cycle, one dividend bit per stage
   for (genvar s = 0; s < MOD_STEPS; s++) begin : g_mod
      logic [CYC_W:0]   trial;
      logic [CYC_W:0]   diff;
      logic [CYC_W-1:0] rem_in;
      always_comb begin
         trial = {mod_rem_ff[s], mod_time_ff[s][TIME_W-1-s]};
         diff  = trial - {1'b0, cfg.cycle};
         if (trial >= {1'b0, cfg.cycle}) rem_in = diff[CYC_W-1:0];
         else rem_in = trial[CYC_W-1:0];
      end
      always_ff @(posedge clock) begin
         mod_rem_ff[s+1]  <= rem_in;
         mod_time_ff[s+1] <= mod_time_ff[s];
      end
   end

   // fold the remainder into a triangle and seed the phase division
   always_comb begin
      two_r = {mod_rem_ff[MOD_STEPS], 1'b0};
      if (two_r < {1'b0, cfg.cycle}) num = two_r;
      else num = {cfg.cycle - mod_rem_ff[MOD_STEPS], 1'b0};
      num_diff = num - {1'b0, cfg.cycle};
      if (num >= {1'b0, cfg.cycle}) begin
         tp_q_in   = FRAC_W'(1);
         tp_rem_in = num_diff[CYC_W-1:0];
      end else begin
         tp_q_in   = '0;
         tp_rem_in = num[CYC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      tp_q_ff[0]   <= tp_q_in;
      tp_rem_ff[0] <= tp_rem_in;
   end

   // phase quotient, one bit per stage
   for (genvar j = 0; j < TP_STEPS; j++) begin : g_tp
      logic [CYC_W:0]    trial;
      logic [CYC_W:0]    diff;
      logic              ge;
      logic [CYC_W-1:0]  rem_in;
      logic [FRAC_W-1:0] q_in;
      always_comb begin
         trial = {tp_rem_ff[j], 1'b0};
         diff  = trial - {1'b0, cfg.cycle};
         ge    = trial >= {1'b0, cfg.cycle};
         if (ge) rem_in = diff[CYC_W-1:0];
         else rem_in = trial[CYC_W-1:0];
         q_in = {tp_q_ff[j][FRAC_W-2:0], ge};
      end
      always_ff @(posedge clock) begin
         tp_rem_ff[j+1] <= rem_in;
         tp_q_ff[j+1]   <= q_in;
      end
   end

   // centre the phase and scale by pi
   always_comb begin
      two_tp = {tp_q_ff[TP_STEPS], 1'b0};
      tp_neg = tp_q_ff[TP_STEPS] < FRAC_W'(ONE_Q16 / 2);
      if (tp_neg) tp_mag = FRAC_W'((FRAC_W + 1)'(ONE_Q16) - two_tp);
      else tp_mag = FRAC_W'(two_tp - (FRAC_W + 1)'(ONE_Q16));
      ang_prod = 35'(tp_mag) * 35'(PI_Q16);
      if (tp_neg) angle_in = -$signed(ang_prod[34:16]);
      else angle_in = $signed(ang_prod[34:16]);
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign out_valid = valid_ff[ANG_LAT-1];
   assign out_angle = angle_ff;

endmodule

>>> sv/twa_ratio.sv
// twa_ratio: offsets from the centre, squared distance and ellipse radius, digit-serial
// square root pipeline and the radial fraction divider. Depends on twa_pkg.
module twa_ratio (
   input  logic                        clock,
   input  twa_pkg::cfg_type            cfg,
   input  logic [twa_pkg::COORD_W-1:0] in_x,
   input  logic [twa_pkg::COORD_W-1:0] in_y,
   output twa_pkg::ratio_type          out_ratio
);
   import twa_pkg::*;

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [IDX_W-1:0]          dest_index;
   } geo_type;

   // stage a
   geo_type         a_geo_ff;
   // stage b
   geo_type         b_geo_ff;
   logic [23:0]     b_dxx_ff, b_dyy_ff, b_cxx_ff, b_cyy_ff;
   // stage c
   geo_type         c_geo_ff;
   logic [24:0]     c_d2_ff;
   logic [47:0]     c_px_ff, c_py_ff;
   // square root stages
   geo_type         sq_geo_ff  [0:SQRT_STEPS];
   logic [24:0]     sq_d2_ff   [0:SQRT_STEPS];
   logic            sq_nz_ff   [0:SQRT_STEPS];
   logic [47:0]     sq_r2_ff   [0:SQRT_STEPS];
   logic [SREM_W-1:0] sq_rem_ff [0:SQRT_STEPS];
   logic [ROOT_W-1:0] sq_root_ff [0:SQRT_STEPS];
   // divider stages
   geo_type         dv_geo_ff  [0:RATIO_STEPS];
   logic            dv_zero_ff [0:RATIO_STEPS];
   logic [ROOT_W-1:0] dv_s8_ff  [0:RATIO_STEPS];
   logic [ROOT_W-1:0] dv_rem_ff [0:RATIO_STEPS];
   logic [15:0]     dv_q_ff    [0:RATIO_STEPS];
   ratio_type       out_ff;

   geo_type                    a_geo_in;
   logic [IDX_W-1:0]           di_sum;
   logic signed [2*DELTA_W-1:0] sqx, sqy;
   logic [ROOT_W:0]            scaled;
   logic                       e_ge;
   ratio_type                  out_in;

   // offsets from the centre and the destination byte index
   always_comb begin
      a_geo_in.dx = $signed({1'b0, in_x}) - $signed({1'b0, cfg.centre_x});
      a_geo_in.dy = $signed({1'b0, in_y}) - $signed({1'b0, cfg.centre_y});
      di_sum = IDX_W'(in_y) * IDX_W'(cfg.width) + IDX_W'(in_x);
      a_geo_in.dest_index = IDX_W'(32'(di_sum) * BYTES_PER_PIXEL);
   end

   always_ff @(posedge clock) begin
      a_geo_ff <= a_geo_in;
   end

   // squares
   assign sqx = a_geo_ff.dx * a_geo_ff.dx;
   assign sqy = a_geo_ff.dy * a_geo_ff.dy;

   always_ff @(posedge clock) begin
      b_geo_ff <= a_geo_ff;
      b_dxx_ff <= sqx[23:0];
      b_dyy_ff <= sqy[23:0];
      b_cxx_ff <= 24'(cfg.centre_x) * 24'(cfg.centre_x);
      b_cyy_ff <= 24'(cfg.centre_y) * 24'(cfg.centre_y);
   end

   // squared distance and weighted products
   always_ff @(posedge clock) begin
      c_geo_ff <= b_geo_ff;
      c_d2_ff  <= 25'(b_dxx_ff) + 25'(b_dyy_ff);
      c_px_ff  <= 48'(b_cxx_ff) * 48'(b_dxx_ff);
      c_py_ff  <= 48'(b_cyy_ff) * 48'(b_dyy_ff);
   end

   // radius squared and square root seed
   always_ff @(posedge clock) begin
      sq_geo_ff[0]  <= c_geo_ff;
      sq_d2_ff[0]   <= c_d2_ff;
      sq_r2_ff[0]   <= c_px_ff + c_py_ff;
      sq_nz_ff[0]   <= (c_d2_ff != '0) && ((c_px_ff + c_py_ff) != '0);
      sq_rem_ff[0]  <= '0;
      sq_root_ff[0] <= '0;
   end

   // square root in Q8, one root bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam int DIGIT = SQRT_STEPS - 1 - k;
      logic [1:0]        pair;
      logic [SREM_W-1:0] rem_w;
      logic [SREM_W-1:0] trial;
      logic [SREM_W-1:0] rem_in;
      logic [ROOT_W-1:0] root_in;
      if (DIGIT >= 8) begin : g_pair
         logic [63:0] wide;
         assign wide = 64'(sq_r2_ff[k]);
         assign pair = wide[2*(DIGIT-8) +: 2];
      end else begin : g_nopair
         assign pair = 2'b00;
      end
      always_comb begin
         rem_w = {sq_rem_ff[k][SREM_W-3:0], pair};
         trial = SREM_W'({sq_root_ff[k], 2'b01});
         if (rem_w >= trial) begin
            rem_in  = rem_w - trial;
            root_in = {sq_root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_w;
            root_in = {sq_root_ff[k][ROOT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         sq_geo_ff[k+1]  <= sq_geo_ff[k];
         sq_d2_ff[k+1]   <= sq_d2_ff[k];
         sq_nz_ff[k+1]   <= sq_nz_ff[k];
         sq_r2_ff[k+1]   <= sq_r2_ff[k];
         sq_rem_ff[k+1]  <= rem_in;
         sq_root_ff[k+1] <= root_in;
      end
   end

   // saturation check seeds the ratio division
   always_comb begin
      scaled = {sq_d2_ff[SQRT_STEPS], 8'b0};
      e_ge   = scaled >= {1'b0, sq_root_ff[SQRT_STEPS]};
   end

   always_ff @(posedge clock) begin
      dv_geo_ff[0]  <= sq_geo_ff[SQRT_STEPS];
      dv_zero_ff[0] <= !sq_nz_ff[SQRT_STEPS] || e_ge;
      dv_s8_ff[0]   <= sq_root_ff[SQRT_STEPS];
      dv_rem_ff[0]  <= scaled[ROOT_W-1:0];
      dv_q_ff[0]    <= '0;
   end

   // ratio quotient, one bit per stage
   for (genvar j = 0; j < RATIO_STEPS; j++) begin : g_div
      logic [ROOT_W:0]   trial;
      logic [ROOT_W:0]   diff;
      logic              ge;
      logic [ROOT_W-1:0] rem_in;
      always_comb begin
         trial = {dv_rem_ff[j], 1'b0};
         diff  = trial - {1'b0, dv_s8_ff[j]};
         ge    = trial >= {1'b0, dv_s8_ff[j]};
         if (ge) rem_in = diff[ROOT_W-1:0];
         else rem_in = trial[ROOT_W-1:0];
      end
      always_ff @(posedge clock) begin
         dv_geo_ff[j+1]  <= dv_geo_ff[j];
         dv_zero_ff[j+1] <= dv_zero_ff[j];
         dv_s8_ff[j+1]   <= dv_s8_ff[j];
         dv_rem_ff[j+1]  <= rem_in;
         dv_q_ff[j+1]    <= {dv_q_ff[j][14:0], ge};
      end
   end

   // fraction = one minus ratio, zero when saturated or degenerate
   always_comb begin
      out_in.dx         = dv_geo_ff[RATIO_STEPS].dx;
      out_in.dy         = dv_geo_ff[RATIO_STEPS].dy;
      out_in.dest_index = dv_geo_ff[RATIO_STEPS].dest_index;
      if (dv_zero_ff[RATIO_STEPS]) out_in.frac = '0;
      else out_in.frac = FRAC_W'(ONE_Q16) - FRAC_W'(dv_q_ff[RATIO_STEPS]);
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_ratio = out_ff;

endmodule

>>> sv/twa_rotate.sv
// twa_rotate: twist scaling, cordic rotation pipeline, source coordinate clamp and the
// source byte index output register. Depends on twa_pkg.
module twa_rotate (
   input  logic                              clock,
   input  logic                              reset,
   input  twa_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   input  logic signed [twa_pkg::ANG_W-1:0]  in_angle,
   input  twa_pkg::ratio_type                in_ratio,
   output logic                              out_valid,
   output logic [twa_pkg::COORD_W-1:0]       out_source_x,
   output logic [twa_pkg::COORD_W-1:0]       out_source_y,
   output logic [twa_pkg::IDX_W-1:0]         out_source_index,
   output logic [twa_pkg::IDX_W-1:0]         out_dest_index
);
   import twa_pkg::*;

   logic [ROT_LAT-1:0]          valid_ff;
   ratio_type                   t_ratio_ff;
   logic signed [CORDIC_W-1:0]  t_twist_ff;
   ratio_type                   cr_ratio_ff [0:CORDIC_STEPS];
   logic                        cr_neg_ff   [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0]  cr_x_ff     [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0]  cr_y_ff     [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0]  cr_z_ff     [0:CORDIC_STEPS];
   ratio_type                   p_ratio_ff;
   logic signed [PROD_W-1:0]    p_xc_ff, p_ys_ff, p_xs_ff, p_yc_ff;
   logic [COORD_W-1:0]          s_x_ff, s_y_ff;
   logic [IDX_W-1:0]            s_dest_ff;
   logic [COORD_W-1:0]          o_x_ff, o_y_ff;
   logic [IDX_W-1:0]            o_src_ff, o_dest_ff;

   logic [ANG_W-1:0]            ang_mag;
   logic [35:0]                 tw_prod;
   logic signed [CORDIC_W-1:0]  twist_in;
   logic signed [CORDIC_W-1:0]  z_in;
   logic                        neg_in;
   logic signed [CORDIC_W-1:0]  cos_v, sin_v;
   logic signed [SUM_W-1:0]     sum_x, sum_y;
   logic [COORD_W-1:0]          sx_in, sy_in;
   logic [IDX_W-1:0]            src_sum;

   // truncate a Q16 sum toward zero and clamp into [0, lim]
   function automatic logic [COORD_W-1:0] place(input logic signed [SUM_W-1:0] v,
                                                input logic [DIM_W-1:0] lim);
      logic signed [SUM_W-1:0] biased;
      logic signed [SUM_W-1:0] q;
      logic [COORD_W-1:0]      r;
      if (v < 0) biased = v + SUM_W'(ONE_Q16 - 1);
      else biased = v;
      q = biased >>> 16;
      if (q < 0) r = '0;
      else if (q > $signed(SUM_W'(lim))) r = lim[COORD_W-1:0];
      else r = q[COORD_W-1:0];
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[ROT_LAT-2:0], in_valid};
   end

   // twist = fraction times angle
   always_comb begin
      if (in_angle < 0) ang_mag = ANG_W'(-in_angle);
      else ang_mag = ANG_W'(in_angle);
      tw_prod = 36'(in_ratio.frac) * 36'(ang_mag);
      if (in_angle < 0) twist_in = -$signed({1'b0, tw_prod[34:16]});
      else twist_in = $signed({1'b0, tw_prod[34:16]});
   end

   always_ff @(posedge clock) begin
      t_ratio_ff <= in_ratio;
      t_twist_ff <= twist_in;
   end

   // fold into the right half plane
   always_comb begin
      if (t_twist_ff > $signed(CORDIC_W'(HALF_PI_Q16))) begin
         z_in   = t_twist_ff - $signed(CORDIC_W'(PI_Q16));
         neg_in = 1'b1;
      end else if (t_twist_ff < -$signed(CORDIC_W'(HALF_PI_Q16))) begin
         z_in   = t_twist_ff + $signed(CORDIC_W'(PI_Q16));
         neg_in = 1'b1;
      end else begin
         z_in   = t_twist_ff;
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cr_ratio_ff[0] <= t_ratio_ff;
      cr_neg_ff[0]   <= neg_in;
      cr_x_ff[0]     <= CORDIC_W'(CORDIC_GAIN);
      cr_y_ff[0]     <= '0;
      cr_z_ff[0]     <= z_in;
   end

   // cordic micro-rotations
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [CORDIC_W-1:0] xs, ys, at;
      logic signed [CORDIC_W-1:0] x_in, y_in, zz_in;
      always_comb begin
         xs = cr_x_ff[i] >>> i;
         ys = cr_y_ff[i] >>> i;
         at = $signed(CORDIC_W'(atan_q16(i)));
         if (cr_z_ff[i] >= 0) begin
            x_in  = cr_x_ff[i] - ys;
            y_in  = cr_y_ff[i] + xs;
            zz_in = cr_z_ff[i] - at;
         end else begin
            x_in  = cr_x_ff[i] + ys;
            y_in  = cr_y_ff[i] - xs;
            zz_in = cr_z_ff[i] + at;
         end
      end
      always_ff @(posedge clock) begin
         cr_ratio_ff[i+1] <= cr_ratio_ff[i];
         cr_neg_ff[i+1]   <= cr_neg_ff[i];
         cr_x_ff[i+1]     <= x_in;
         cr_y_ff[i+1]     <= y_in;
         cr_z_ff[i+1]     <= zz_in;
      end
   end

   // rotation products
   always_comb begin
      if (cr_neg_ff[CORDIC_STEPS]) begin
         cos_v = -cr_x_ff[CORDIC_STEPS];
         sin_v = -cr_y_ff[CORDIC_STEPS];
      end else begin
         cos_v = cr_x_ff[CORDIC_STEPS];
         sin_v = cr_y_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      p_ratio_ff <= cr_ratio_ff[CORDIC_STEPS];
      p_xc_ff    <= PROD_W'(cr_ratio_ff[CORDIC_STEPS].dx) * PROD_W'(cos_v);
      p_ys_ff    <= PROD_W'(cr_ratio_ff[CORDIC_STEPS].dy) * PROD_W'(sin_v);
      p_xs_ff    <= PROD_W'(cr_ratio_ff[CORDIC_STEPS].dx) * PROD_W'(sin_v);
      p_yc_ff    <= PROD_W'(cr_ratio_ff[CORDIC_STEPS].dy) * PROD_W'(cos_v);
   end

   // source coordinates about the centre
   always_comb begin
      sum_x = $signed(SUM_W'({cfg.centre_x, 16'b0})) + SUM_W'(p_xc_ff) - SUM_W'(p_ys_ff);
      sum_y = $signed(SUM_W'({cfg.centre_y, 16'b0})) + SUM_W'(p_xs_ff) + SUM_W'(p_yc_ff);
      sx_in = place(sum_x, cfg.width - DIM_W'(1));
      sy_in = place(sum_y, cfg.height - DIM_W'(1));
   end

   always_ff @(posedge clock) begin
      s_x_ff    <= sx_in;
      s_y_ff    <= sy_in;
      s_dest_ff <= p_ratio_ff.dest_index;
   end

   // source byte index and output register
   assign src_sum = IDX_W'(s_y_ff) * IDX_W'(cfg.width) + IDX_W'(s_x_ff);

   always_ff @(posedge clock) begin
      o_x_ff    <= s_x_ff;
      o_y_ff    <= s_y_ff;
      o_src_ff  <= IDX_W'(32'(src_sum) * BYTES_PER_PIXEL);
      o_dest_ff <= s_dest_ff;
   end

   assign out_valid        = valid_ff[ROT_LAT-1];
   assign out_source_x     = o_x_ff;
   assign out_source_y     = o_y_ff;
   assign out_source_index = o_src_ff;
   assign out_dest_index   = o_dest_ff;

endmodule

>>> sv/twist_warp_source_address_core.sv
// twist_warp_source_address_core: top level with the configuration registers, the angle and
// ratio pipelines, the alignment delay and the rotator. Depends on twa_pkg and all twa_ modules.
//
//  channel   ports                                      transfer
//  request   start, busy, req_dest_x/y, req_frame_time  start high and busy low
//  response  rsp_valid, rsp_source_x/y, rsp_*_index     one cycle per strobe
//  config    csr_write_enable, csr_index, csr_write_data  write enable high
//
// One transaction per clock; the depth of the result path is set by the one-bit-per-stage
// modulo of the 63-bit time and the phase divider.
// busy never rises: the pipeline has no stall point and the receiver cannot hold results off.
// Synchronous reset clears the valid bits and restores the register defaults.
module twist_warp_source_address_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [twa_pkg::COORD_W-1:0]    req_dest_x,
   input  logic [twa_pkg::COORD_W-1:0]    req_dest_y,
   input  logic [twa_pkg::TIME_W-1:0]     req_frame_time,
   output logic                           rsp_valid,
   output logic [twa_pkg::COORD_W-1:0]    rsp_source_x,
   output logic [twa_pkg::COORD_W-1:0]    rsp_source_y,
   output logic [twa_pkg::IDX_W-1:0]      rsp_source_index,
   output logic [twa_pkg::IDX_W-1:0]      rsp_dest_index,
   input  logic                           csr_write_enable,
   input  logic [twa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [twa_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import twa_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [CYC_W-1:0] cycle_ff;
   cfg_type          cfg;
   logic             req_accept;
   logic             ang_valid;
   logic signed [ANG_W-1:0] ang_value;
   ratio_type        rat_value;
   ratio_type        pad_ff [0:PAD_LAT-1];
   logic [DIM_W-1:0] width_eff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         cycle_ff  <= CYC_W'(20000000);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_WIDTH:  width_ff  <= csr_write_data[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_write_data[DIM_W-1:0];
            CSR_CYCLE:  cycle_ff  <= csr_write_data[CYC_W-1:0];
            default: ;
         endcase
      end
   end

   // effective dimensions and centre
   always_comb begin
      width_eff    = eff_dim(width_ff);
      cfg.width    = width_eff;
      cfg.height   = eff_dim(height_ff);
      cfg.centre_x = cfg.width[DIM_W-1:1];
      cfg.centre_y = cfg.height[DIM_W-1:1];
      cfg.cycle    = (cycle_ff == '0) ? CYC_W'(1) : cycle_ff;
   end

   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   twa_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_accept),
      .in_time   (req_frame_time),
      .out_valid (ang_valid),
      .out_angle (ang_value)
   );

   twa_ratio u_ratio (
      .clock     (clock),
      .cfg       (cfg),
      .in_x      (req_dest_x),
      .in_y      (req_dest_y),
      .out_ratio (rat_value)
   );

   // line up the geometry with the slower angle path
   always_ff @(posedge clock) begin
      pad_ff[0] <= rat_value;
      for (int k = 1; k < PAD_LAT; k++) begin
         pad_ff[k] <= pad_ff[k-1];
      end
   end

   twa_rotate u_rotate (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .in_valid         (ang_valid),
      .in_angle         (ang_value),
      .in_ratio         (pad_ff[PAD_LAT-1]),
      .out_valid        (rsp_valid),
      .out_source_x     (rsp_source_x),
      .out_source_y     (rsp_source_y),
      .out_source_index (rsp_source_index),
      .out_dest_index   (rsp_dest_index)
   );

endmodule
